@@ rtl/pop_pkg.sv @@
// Shared types, codes and constants of the perpetual option pricer.
// Holds the sequencer states, unit request structs and the 2^(2^-k) table.
// No dependencies.
package pop_pkg;

    // Default number of fraction bits on the ports
    localparam int FRAC_BITS_DEF = 16;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIKE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CARRY      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLATILITY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IS_PUT     = 3'd4;

    // Register reset values
    localparam logic [31:0] STRIKE_RST = 32'd7208960;
    localparam logic [31:0] RATE_RST   = 32'd3277;
    localparam logic [31:0] CARRY_RST  = 32'd3277;
    localparam logic [31:0] VOL_RST    = 32'd13107;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SAT   = 2'd1;
    localparam logic [1:0] STATUS_UNDEF = 2'd2;

    // Q.32 constants and clamps; EXP_ONE is one in Q.60
    localparam logic signed [63:0] HALF_Q32 = 64'sh0000_0000_8000_0000;
    localparam logic signed [63:0] ONE_Q32  = 64'sh0000_0001_0000_0000;
    localparam logic signed [63:0] TMP_LIM  = 64'sh0000_8000_0000_0000;
    localparam logic [63:0] CAP_B    = 64'h0000_8000_0000_0000;
    localparam logic [63:0] CAP_R    = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MUL_CAP  = 64'h4000_0000_0000_0000;
    localparam logic [63:0] HI_LIM   = 64'h0000_0000_4000_0000;
    localparam logic [63:0] EXP_ONE  = 64'h1000_0000_0000_0000;
    localparam logic [6:0]  SQRT_STEPS = 7'd48;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_V2_WAIT,
        S_DIVB_GO,
        S_DIVB_WAIT,
        S_DIVR_GO,
        S_DIVR_WAIT,
        S_DCHK,
        S_SQRT_WAIT,
        S_YCHK,
        S_LOG_NORM,
        S_LOG_SQ_GO,
        S_LOG_SQ_WAIT,
        S_LOG_STORE,
        S_YMUL_GO,
        S_YMUL_WAIT,
        S_EXP_CHK,
        S_EXP_STEP,
        S_EXP_WAIT,
        S_PRICE,
        S_OUT
    } state_t;

    // Request to the shared multiplier
    typedef struct packed {
        logic        start;
        logic        wide;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    // Request to the shared divide / square root unit
    typedef struct packed {
        logic        start;
        logic        sqrt_mode;
        logic [6:0]  steps;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] cap;
    } ds_req_t;

    typedef logic [31:0][63:0] pow_tab_t;

    // floor(sqrt(x * 4^zp)), digit by digit
    function automatic logic [63:0] isqrt_sh(input logic [63:0] x, input int zp);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] trial;
        logic [63:0] pair;
        rem  = '0;
        root = '0;
        for (int i = 0; i < 32 + zp; i++) begin
            pair  = (i < 32) ? ((x >> (62 - 2 * i)) & 64'd3) : 64'd0;
            rem   = (rem << 2) | pair;
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    // 2^(2^-(k+1)) for entry k, in Q.60, by repeated square roots of two
    function automatic pow_tab_t build_pow_tab();
        pow_tab_t    t;
        logic [63:0] c;
        c = 64'd2 << 60;
        for (int k = 0; k < 32; k++) begin
            c    = isqrt_sh(c, 30);
            t[k] = c;
        end
        return t;
    endfunction

    localparam pow_tab_t POW_TAB = build_pow_tab();

endpackage

@@ rtl/pop_if.sv @@
// Valid/ready channel interfaces of the perpetual option pricer.
// Spot items in, price items out, configuration writes. Depends on nothing.
interface pop_spot_if;
    logic        valid;
    logic        ready;
    logic [31:0] spot;

    modport source (output valid, output spot, input ready);
    modport sink   (input valid, input spot, output ready);
endinterface

interface pop_price_if;
    logic        valid;
    logic        ready;
    logic [31:0] price;
    logic [1:0]  status;

    modport source (output valid, output price, output status, input ready);
    modport sink   (input valid, input price, input status, output ready);
endinterface

interface pop_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/pop_mul.sv @@
// Shared multiplier: one 32x32 multiply-accumulate step per cycle.
// Narrow requests take one step, wide 64x64 requests take four. Uses pop_pkg.
module pop_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  pop_pkg::mul_req_t req,
    output logic              done,
    output logic [127:0]      prod
);
    import pop_pkg::*;

    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [127:0] acc_reg;
    logic [1:0]   step_reg;
    logic         wide_reg;
    logic         busy_reg;
    logic         done_reg;

    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [63:0]  pp;
    logic [6:0]   pp_sh;
    logic [127:0] pp_ext;
    logic         last;

    // Select the partial product of this step
    always_comb
    begin
        a_half = step_reg[1] ? a_reg[63:32] : a_reg[31:0];
        b_half = step_reg[0] ? b_reg[63:32] : b_reg[31:0];
        pp     = 64'(a_half) * 64'(b_half);
        pp_sh  = {step_reg[1] & step_reg[0], step_reg[1] ^ step_reg[0], 5'd0};
        pp_ext = {64'd0, pp} << pp_sh;
        last   = wide_reg ? (step_reg == 2'd3) : 1'b1;
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (req.start)
                busy_reg <= 1'b1;
            else if (busy_reg && last)
                busy_reg <= 1'b0;
        end
    end

    // Accumulate
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg    <= req.a;
            b_reg    <= req.b;
            wide_reg <= req.wide;
            acc_reg  <= '0;
            step_reg <= 2'd0;
        end
        else if (busy_reg)
        begin
            acc_reg  <= acc_reg + pp_ext;
            step_reg <= step_reg + 2'd1;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

@@ rtl/pop_divsqrt.sv @@
// Shared shift-subtract unit: restoring division or digit-by-digit square root,
// one quotient or root bit per cycle. Uses pop_pkg.
module pop_divsqrt (
    input  logic             clk,
    input  logic             rst_n,
    input  pop_pkg::ds_req_t req,
    output logic             done,
    output logic [63:0]      result
);
    import pop_pkg::*;

    logic [63:0] x_reg;
    logic [63:0] den_reg;
    logic [63:0] cap_reg;
    logic [63:0] rem_reg;
    logic [63:0] q_reg;
    logic [6:0]  steps_reg;
    logic [6:0]  cnt_reg;
    logic        sqrt_reg;
    logic        over_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [63:0] rem_div;
    logic [63:0] rem_sqrt;
    logic [63:0] op_a;
    logic [63:0] op_b;
    logic [64:0] diff;
    logic        take;
    logic [63:0] q_next;
    logic        last;

    // One step: shared subtract and compare
    always_comb
    begin
        rem_div  = {rem_reg[62:0], x_reg[63]};
        rem_sqrt = {rem_reg[61:0], x_reg[63:62]};
        op_a     = sqrt_reg ? rem_sqrt : rem_div;
        op_b     = sqrt_reg ? {q_reg[61:0], 2'b01} : den_reg;
        diff     = {1'b0, op_a} - {1'b0, op_b};
        take     = sqrt_reg ? !diff[64] : (rem_reg[63] || !diff[64]);
        q_next   = {q_reg[62:0], take};
        last     = (cnt_reg == steps_reg - 7'd1);
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (req.start)
                busy_reg <= 1'b1;
            else if (busy_reg && last)
                busy_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg     <= req.num;
            den_reg   <= req.den;
            cap_reg   <= req.cap;
            steps_reg <= req.steps;
            sqrt_reg  <= req.sqrt_mode;
            rem_reg   <= '0;
            q_reg     <= '0;
            cnt_reg   <= '0;
            over_reg  <= 1'b0;
        end
        else if (busy_reg)
        begin
            x_reg    <= sqrt_reg ? {x_reg[61:0], 2'b00} : {x_reg[62:0], 1'b0};
            rem_reg  <= take ? diff[63:0] : op_a;
            q_reg    <= q_next;
            cnt_reg  <= cnt_reg + 7'd1;
            // once past the cap the quotient stays past it
            over_reg <= over_reg || (q_next > cap_reg);
        end
    end

    assign done   = done_reg;
    assign result = (!sqrt_reg && over_reg) ? cap_reg : q_reg;

endmodule

@@ rtl/perpetual_option_pricer.sv @@
// Perpetual American option pricer, top level: registers, sequencer, output stage.
// Depends on pop_pkg, the channel interfaces, pop_mul and pop_divsqrt.
//
// Usage:
//   cfg    - register writes (strike, rate, carry, volatility, put flag), always
//            ready; write only while no item is in flight.
//   spots  - one spot price per item; ready only while the sequencer is idle.
//   prices - price and status per item, held in an output register.
// Each item runs through one shared divide/square-root unit and one shared
// 32x32 multiplier under the sequencer: two divisions of 64+FRAC_BITS+32 and
// 64+FRAC_BITS+33 steps, a 48-step square root, four logarithms of a
// normalization and 32 squarings each, and up to 32 products for 2^x.
// Undefined inputs (zero strike, volatility or spot) give a zero result with
// undefined status straight from the check state, without the shared units.
// No new spot is taken until the previous item has left the sequencer.
// Reset puts the configuration registers to their defaults, the sequencer to idle and empties the output stage.
// A stalled receiver holds the result; the next item may already be accepted
// and waits to be delivered until the output register is free.
module perpetual_option_pricer #(
    parameter int FRAC_BITS = pop_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    pop_cfg_if.sink      cfg,
    pop_spot_if.sink     spots,
    pop_price_if.source  prices
);
    import pop_pkg::*;

    localparam logic [6:0] DIVB_STEPS = 7'(64 + FRAC_BITS + 32);
    localparam logic [6:0] DIVR_STEPS = 7'(64 + FRAC_BITS + 33);
    localparam logic signed [7:0] FB_LOG = 8'(FRAC_BITS);
    localparam logic signed [63:0] FB_OFS = $signed({32'(FRAC_BITS), 32'd0});

    // Configuration registers
    logic [31:0] strike_reg;
    logic [31:0] rate_reg;
    logic [31:0] carry_reg;
    logic [31:0] vol_reg;
    logic        put_reg;

    // Sequencer and datapath registers
    state_t             state_reg, state_next;
    logic [31:0]        spot_reg, spot_next;
    logic [63:0]        v2_reg, v2_next;
    logic signed [63:0] tmp_reg, tmp_next;
    logic signed [63:0] q_reg, q_next;
    logic [63:0]        tsq_reg, tsq_next;
    logic signed [63:0] y_reg, y_next;
    logic [1:0]         sel_reg, sel_next;
    logic [63:0]        norm_reg, norm_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [31:0]        m_reg, m_next;
    logic [31:0]        frac_reg, frac_next;
    logic [4:0]         it_reg, it_next;
    logic signed [63:0] log_reg [4];
    logic               log_we;
    logic               neg_reg, neg_next;
    logic signed [63:0] x_reg, x_next;
    logic signed [5:0]  n_reg, n_next;
    logic [63:0]        r_reg, r_next;
    logic [31:0]        res_price_reg, res_price_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        out_price_reg, out_price_next;
    logic [1:0]         out_status_reg, out_status_next;

    // Shared units
    mul_req_t     mul_req;
    logic         mul_done;
    logic [127:0] mul_prod;
    ds_req_t      ds_req;
    logic         ds_done;
    logic [63:0]  ds_res;

    pop_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    pop_divsqrt u_divsqrt (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (ds_req),
        .done   (ds_done),
        .result (ds_res)
    );

    // Datapath helpers
    logic [31:0]        b_mag;
    logic [31:0]        r_mag;
    logic signed [63:0] sbs;
    logic signed [63:0] tmp_calc;
    logic signed [63:0] tmp_sat;
    logic [63:0]        tmp_mag;
    logic signed [64:0] d_sum;
    logic signed [63:0] y_calc;
    logic signed [63:0] ym1;
    logic [63:0]        log_raw [4];
    logic signed [7:0]  fb_cur;
    logic signed [7:0]  lexp;
    logic signed [63:0] log_val;
    logic [32:0]        m_sq;
    logic signed [63:0] dd;
    logic [63:0]        dd_mag;
    logic [63:0]        y_mag;
    logic [63:0]        prod_mag;
    logic signed [63:0] prod_s;
    logic signed [31:0] n_full;
    logic [6:0]         p_sh;
    logic [63:0]        p_shifted;

    always_comb
    begin
        b_mag    = carry_reg[31] ? (~carry_reg + 32'd1) : carry_reg;
        r_mag    = rate_reg[31] ? (~rate_reg + 32'd1) : rate_reg;
        sbs      = carry_reg[31] ? -$signed(ds_res) : $signed(ds_res);
        tmp_calc = HALF_Q32 - sbs;
        if (tmp_calc > TMP_LIM)
            tmp_sat = TMP_LIM;
        else if (tmp_calc < -TMP_LIM)
            tmp_sat = -TMP_LIM;
        else
            tmp_sat = tmp_calc;
        tmp_mag  = tmp_reg[63] ? 64'(-tmp_reg) : 64'(tmp_reg);
        d_sum    = $signed({1'b0, tsq_reg}) + $signed({q_reg[63], q_reg});
        y_calc   = put_reg ? (tmp_reg - $signed(ds_res)) : (tmp_reg + $signed(ds_res));
        ym1      = y_reg - ONE_Q32;
        y_mag    = y_reg[63] ? 64'(-y_reg) : 64'(y_reg);
        log_raw[0] = {32'd0, strike_reg};
        log_raw[1] = {32'd0, spot_reg};
        log_raw[2] = ym1[63] ? 64'(-ym1) : 64'(ym1);
        log_raw[3] = y_mag;
        fb_cur   = sel_reg[1] ? 8'sd32 : FB_LOG;
        lexp     = 8'sd63 - $signed({2'b00, cnt_reg}) - fb_cur;
        log_val  = $signed({{24{lexp[7]}}, lexp, frac_reg});
        m_sq     = mul_prod[63:31];
        dd       = log_reg[2] - log_reg[3] + log_reg[1] - log_reg[0];
        dd_mag   = dd[63] ? 64'(-dd) : 64'(dd);
        if (mul_prod[127:64] >= HI_LIM)
            prod_mag = MUL_CAP;
        else if (mul_prod[95:32] > MUL_CAP)
            prod_mag = MUL_CAP;
        else
            prod_mag = mul_prod[95:32];
        prod_s   = neg_reg ? -$signed(prod_mag) : $signed(prod_mag);
        n_full   = $signed(x_reg[63:32]);
        p_sh     = 7'd60 - 7'($signed(n_reg));
        p_shifted = r_reg >> p_sh[5:0];
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        spot_next       = spot_reg;
        v2_next         = v2_reg;
        tmp_next        = tmp_reg;
        q_next          = q_reg;
        tsq_next        = tsq_reg;
        y_next          = y_reg;
        sel_next        = sel_reg;
        norm_next       = norm_reg;
        cnt_next        = cnt_reg;
        m_next          = m_reg;
        frac_next       = frac_reg;
        it_next         = it_reg;
        log_we          = 1'b0;
        neg_next        = neg_reg;
        x_next          = x_reg;
        n_next          = n_reg;
        r_next          = r_reg;
        res_price_next  = res_price_reg;
        res_status_next = res_status_reg;
        mul_req         = '0;
        ds_req          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (spots.valid)
                begin
                    spot_next  = spots.spot;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (vol_reg == '0 || strike_reg == '0 || spot_reg == '0)
                begin
                    res_price_next  = '0;
                    res_status_next = STATUS_UNDEF;
                    state_next      = S_OUT;
                end
                else
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = {32'd0, vol_reg};
                    mul_req.b     = {32'd0, vol_reg};
                    state_next    = S_V2_WAIT;
                end
            end
            S_V2_WAIT:
            begin
                if (mul_done)
                begin
                    v2_next    = mul_prod[63:0];
                    state_next = S_DIVB_GO;
                end
            end
            S_DIVB_GO:
            begin
                ds_req.start = 1'b1;
                ds_req.steps = DIVB_STEPS;
                ds_req.num   = {32'd0, b_mag};
                ds_req.den   = v2_reg;
                ds_req.cap   = CAP_B;
                state_next   = S_DIVB_WAIT;
            end
            S_DIVB_WAIT:
            begin
                if (ds_done)
                begin
                    tmp_next   = tmp_sat;
                    state_next = S_DIVR_GO;
                end
            end
            S_DIVR_GO:
            begin
                // tmp squared runs on the multiplier beside the division
                ds_req.start  = 1'b1;
                ds_req.steps  = DIVR_STEPS;
                ds_req.num    = {32'd0, r_mag};
                ds_req.den    = v2_reg;
                ds_req.cap    = CAP_R;
                mul_req.start = 1'b1;
                mul_req.wide  = 1'b1;
                mul_req.a     = tmp_mag;
                mul_req.b     = tmp_mag;
                state_next    = S_DIVR_WAIT;
            end
            S_DIVR_WAIT:
            begin
                if (mul_done)
                    tsq_next = mul_prod[95:32];
                if (ds_done)
                begin
                    q_next     = rate_reg[31] ? -$signed(ds_res) : $signed(ds_res);
                    state_next = S_DCHK;
                end
            end
            S_DCHK:
            begin
                if (d_sum[64])
                begin
                    res_price_next  = '0;
                    res_status_next = STATUS_UNDEF;
                    state_next      = S_OUT;
                end
                else
                begin
                    ds_req.start     = 1'b1;
                    ds_req.sqrt_mode = 1'b1;
                    ds_req.steps     = SQRT_STEPS;
                    ds_req.num       = d_sum[63:0];
                    state_next       = S_SQRT_WAIT;
                end
            end
            S_SQRT_WAIT:
            begin
                if (ds_done)
                begin
                    y_next     = y_calc;
                    state_next = S_YCHK;
                end
            end
            S_YCHK:
            begin
                if (!(y_reg > ONE_Q32 || y_reg[63]))
                begin
                    res_price_next  = '0;
                    res_status_next = STATUS_UNDEF;
                    state_next      = S_OUT;
                end
                else
                begin
                    sel_next   = 2'd0;
                    norm_next  = log_raw[0];
                    cnt_next   = '0;
                    state_next = S_LOG_NORM;
                end
            end
            S_LOG_NORM:
            begin
                // shift the leading one to the top, a byte or a bit at a time
                if (norm_reg[63:56] == 8'd0)
                begin
                    norm_next = {norm_reg[55:0], 8'd0};
                    cnt_next  = cnt_reg + 6'd8;
                end
                else if (!norm_reg[63])
                begin
                    norm_next = {norm_reg[62:0], 1'b0};
                    cnt_next  = cnt_reg + 6'd1;
                end
                else
                begin
                    m_next     = norm_reg[63:32];
                    frac_next  = '0;
                    it_next    = '0;
                    state_next = S_LOG_SQ_GO;
                end
            end
            S_LOG_SQ_GO:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = {32'd0, m_reg};
                mul_req.b     = {32'd0, m_reg};
                state_next    = S_LOG_SQ_WAIT;
            end
            S_LOG_SQ_WAIT:
            begin
                if (mul_done)
                begin
                    if (m_sq[32])
                    begin
                        m_next    = m_sq[32:1];
                        frac_next = {frac_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        m_next    = m_sq[31:0];
                        frac_next = {frac_reg[30:0], 1'b0};
                    end
                    it_next    = it_reg + 5'd1;
                    state_next = (it_reg == 5'd31) ? S_LOG_STORE : S_LOG_SQ_GO;
                end
            end
            S_LOG_STORE:
            begin
                log_we = 1'b1;
                if (sel_reg == 2'd3)
                    state_next = S_YMUL_GO;
                else
                begin
                    sel_next   = sel_reg + 2'd1;
                    norm_next  = log_raw[sel_reg + 2'd1];
                    cnt_next   = '0;
                    state_next = S_LOG_NORM;
                end
            end
            S_YMUL_GO:
            begin
                mul_req.start = 1'b1;
                mul_req.wide  = 1'b1;
                mul_req.a     = y_mag;
                mul_req.b     = dd_mag;
                neg_next      = y_reg[63] ^ dd[63];
                state_next    = S_YMUL_WAIT;
            end
            S_YMUL_WAIT:
            begin
                if (mul_done)
                begin
                    x_next     = log_reg[0] - log_reg[2] + prod_s + FB_OFS;
                    state_next = S_EXP_CHK;
                end
            end
            S_EXP_CHK:
            begin
                if (n_full > 32'sd31)
                begin
                    res_price_next  = '1;
                    res_status_next = STATUS_SAT;
                    state_next      = S_OUT;
                end
                else if (n_full < -32'sd3)
                begin
                    res_price_next  = '0;
                    res_status_next = STATUS_OK;
                    state_next      = S_OUT;
                end
                else
                begin
                    n_next     = 6'(n_full);
                    frac_next  = x_reg[31:0];
                    r_next     = EXP_ONE;
                    it_next    = '0;
                    state_next = S_EXP_STEP;
                end
            end
            S_EXP_STEP:
            begin
                // multiply only where the fraction bit is set
                if (frac_reg[31])
                begin
                    mul_req.start = 1'b1;
                    mul_req.wide  = 1'b1;
                    mul_req.a     = r_reg;
                    mul_req.b     = POW_TAB[it_reg];
                    state_next    = S_EXP_WAIT;
                end
                else
                begin
                    frac_next  = {frac_reg[30:0], 1'b0};
                    it_next    = it_reg + 5'd1;
                    state_next = (it_reg == 5'd31) ? S_PRICE : S_EXP_STEP;
                end
            end
            S_EXP_WAIT:
            begin
                if (mul_done)
                begin
                    r_next     = mul_prod[123:60];
                    frac_next  = {frac_reg[30:0], 1'b0};
                    it_next    = it_reg + 5'd1;
                    state_next = (it_reg == 5'd31) ? S_PRICE : S_EXP_STEP;
                end
            end
            S_PRICE:
            begin
                res_price_next  = p_shifted[31:0];
                res_status_next = STATUS_OK;
                state_next      = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || prices.ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output stage: load when the sequencer finishes, drop when taken
    always_comb
    begin
        out_valid_next  = out_valid_reg && !prices.ready;
        out_price_next  = out_price_reg;
        out_status_next = out_status_reg;
        if (state_reg == S_OUT && (!out_valid_reg || prices.ready))
        begin
            out_valid_next  = 1'b1;
            out_price_next  = res_price_reg;
            out_status_next = res_status_reg;
        end
    end

    // Control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            strike_reg    <= STRIKE_RST;
            rate_reg      <= RATE_RST;
            carry_reg     <= CARRY_RST;
            vol_reg       <= VOL_RST;
            put_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    CFG_STRIKE:     strike_reg <= cfg.data;
                    CFG_RATE:       rate_reg   <= cfg.data;
                    CFG_CARRY:      carry_reg  <= cfg.data;
                    CFG_VOLATILITY: vol_reg    <= cfg.data;
                    CFG_IS_PUT:     put_reg    <= cfg.data[0];
                    default:        ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        spot_reg       <= spot_next;
        v2_reg         <= v2_next;
        tmp_reg        <= tmp_next;
        q_reg          <= q_next;
        tsq_reg        <= tsq_next;
        y_reg          <= y_next;
        sel_reg        <= sel_next;
        norm_reg       <= norm_next;
        cnt_reg        <= cnt_next;
        m_reg          <= m_next;
        frac_reg       <= frac_next;
        it_reg         <= it_next;
        neg_reg        <= neg_next;
        x_reg          <= x_next;
        n_reg          <= n_next;
        r_reg          <= r_next;
        res_price_reg  <= res_price_next;
        res_status_reg <= res_status_next;
        out_price_reg  <= out_price_next;
        out_status_reg <= out_status_next;
        if (log_we)
            log_reg[sel_reg] <= log_val;
    end

    assign cfg.ready     = 1'b1;
    assign spots.ready   = (state_reg == S_IDLE);
    assign prices.valid  = out_valid_reg;
    assign prices.price  = out_price_reg;
    assign prices.status = out_status_reg;

endmodule

@@ rtl/pop_checker.sv @@
// Port-level checks of the perpetual option pricer, bound to the top level.
// Depends on pop_pkg for the status codes.
module pop_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] price,
    input logic [1:0]  status
);
    import pop_pkg::*;

    // Undefined results carry a zero price
    a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_UNDEF |-> price == 32'd0)
        else $error("undefined result with nonzero price");

    // Saturated results carry the maximum price
    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_SAT |-> price == 32'hFFFF_FFFF)
        else $error("saturated result below maximum");

    // One item at a time: input closes right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after an accepted item");

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(price) && $stable(status))
        else $error("stalled result changed");

endmodule

bind perpetual_option_pricer pop_checker u_pop_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (spots.valid),
    .in_ready  (spots.ready),
    .out_valid (prices.valid),
    .out_ready (prices.ready),
    .price     (prices.price),
    .status    (prices.status)
);
